[hdl/elc_pkg.sv]
// Package with shared types, constants and codes of the letter cipher.
`timescale 1ns / 1ps
`default_nettype none
package elc_pkg;
  localparam int unsigned WordBitsDefault = 16;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned ReqBits = 2;
  localparam int unsigned OpdBits = 16;

  localparam logic [ReqBits-1:0] ReqSession = 2'd0;
  localparam logic [ReqBits-1:0] ReqEncrypt = 2'd1;
  localparam logic [ReqBits-1:0] ReqDecrypt = 2'd2;

  localparam logic [CfgIdxBits-1:0] CfgModulus    = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgGenerator  = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgPublicKey  = 2'd2;
  localparam logic [CfgIdxBits-1:0] CfgPrivateKey = 2'd3;

  localparam logic [7:0] LetterFirst = 8'h61;
  localparam logic [7:0] LetterLast  = 8'h7a;
  localparam logic [7:0] LetterBase  = 8'd1;

  // Datapath operations selected by the controller.
  typedef enum logic [3:0] {
    OpNone   = 4'd0,
    OpLoadS  = 4'd1,  // acc=1 mod p, sq=generator mod p
    OpLoadE  = 4'd2,  // acc=1 mod p, sq=public_key mod p
    OpLoadD  = 4'd3,  // acc=1 mod p, sq=c1 mod p
    OpMulAcc = 4'd4,  // acc = acc*sq mod p
    OpMulSq  = 4'd5,  // sq = sq*sq mod p
    OpSaveC1 = 4'd6,
    OpSaveK  = 4'd7,
    OpInvIni = 4'd8,
    OpInvDiv = 4'd9,
    OpInvEnd = 4'd10,
    OpEncMul = 4'd11,
    OpDecMul = 4'd12
  } op_e;

  typedef struct packed {
    op_e  op;
    logic start;  // begin the selected operation
  } dp_cmd_t;

  typedef struct packed {
    logic busy;     // multiplier or divider running
    logic exp_bit;  // current exponent bit
    logic r1_zero;  // Euclid remainder is zero
    logic letter;   // encrypt operand is a lowercase letter
    logic miss;     // inverse missing flag
  } dp_sts_t;
endpackage
`default_nettype wire

[hdl/elc_if.sv]
// Valid/ready channel interface carrying request or result payload.
`timescale 1ns / 1ps
`default_nettype none
interface elc_if #(
  parameter int unsigned W = 16
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/elc_dp.sv]
// Datapath: registers, shift-add modular multiplier and restoring divider.
`timescale 1ns / 1ps
`default_nettype none
module elc_dp #(
  parameter int unsigned WordBits = elc_pkg::WordBitsDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [elc_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  wire logic [WordBits-1:0]          cfg_data_i,
  input  wire logic                         ld_i,
  input  wire logic [elc_pkg::OpdBits-1:0]  opd_i,
  input  wire logic [5:0]                   bit_idx_i,
  input  wire elc_pkg::dp_cmd_t             cmd_i,
  output elc_pkg::dp_sts_t                  sts_o,
  output logic [elc_pkg::OpdBits-1:0]       res_o
);
  localparam int unsigned CntBits = $clog2(WordBits + 1);
  localparam int unsigned Sw = WordBits + 2;

  logic [WordBits-1:0] mod_q, gen_q, pub_q, prv_q;
  logic [WordBits-1:0] opd_q, c1_q, k_q, kinv_q, acc_q, sq_q, exp_q;
  logic                miss_q;
  logic [WordBits-1:0] res_q;
  logic [WordBits-1:0] ma_q, mb_q, mb2_q, mp_q;
  logic [CntBits-1:0]  mcnt_q;
  logic                mbusy_q;
  logic                mpre_q;
  logic [1:0]          mdst_q;
  logic [WordBits-1:0] r0_q, r1_q, dq_q, drem_q, dn_q;
  logic signed [Sw-1:0] t0_q, t1_q;
  logic [CntBits-1:0]  dcnt_q;
  logic                dbusy_q;
  logic [WordBits:0]   dbl, dbl_red, sum, sum_red, rtry;
  logic [WordBits-1:0] red_a, red_b, ra, rb;
  logic [WordBits-1:0] letter_m, one_red;
  logic                mul_pre;
  logic [7:0]          ch;

  // The partial product stays below p, so the added operand must already be below p.
  assign ch = opd_q[7:0];
  assign letter_m = WordBits'(ch - elc_pkg::LetterFirst + elc_pkg::LetterBase);
  assign one_red  = (mod_q >= WordBits'(2)) ? WordBits'(1) : '0;
  assign mul_pre  = (cmd_i.op == elc_pkg::OpEncMul) || (cmd_i.op == elc_pkg::OpDecMul);

  // Shift-add step: p = 2p + (bit ? a : 0), each reduced once.
  assign dbl     = {mp_q, 1'b0};
  assign dbl_red = (dbl >= {1'b0, mod_q}) ? dbl - {1'b0, mod_q} : dbl;
  assign sum     = dbl_red + (mb_q[WordBits-1] ? {1'b0, ma_q} : '0);
  assign sum_red = (sum >= {1'b0, mod_q}) ? sum - {1'b0, mod_q} : sum;
  assign rtry    = {drem_q, dn_q[WordBits-1]};

  always_comb begin
    ra = acc_q;
    rb = sq_q;
    case (cmd_i.op)
      elc_pkg::OpMulSq:  ra = sq_q;
      elc_pkg::OpEncMul: begin ra = letter_m; rb = k_q; end
      elc_pkg::OpDecMul: begin ra = opd_q; rb = kinv_q; end
      default: ;
    endcase
  end
  // Encrypt and decrypt operands may be at or above p; a first multiplier pass
  // forms (1 mod p) * a, which reduces the first operand before the product.
  assign red_a = ra;
  assign red_b = rb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q   <= WordBits'(29);
      gen_q   <= WordBits'(2);
      pub_q   <= WordBits'(1);
      prv_q   <= '0;
      c1_q    <= '0;
      k_q     <= '0;
      kinv_q  <= '0;
      miss_q  <= 1'b1;
      mbusy_q <= 1'b0;
      mpre_q  <= 1'b0;
      dbusy_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          elc_pkg::CfgModulus:    mod_q <= cfg_data_i;
          elc_pkg::CfgGenerator:  gen_q <= cfg_data_i;
          elc_pkg::CfgPublicKey:  pub_q <= cfg_data_i;
          elc_pkg::CfgPrivateKey: prv_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (mbusy_q) begin
        if (mpre_q && mcnt_q == CntBits'(1)) begin
          ma_q   <= sum_red[WordBits-1:0];
          mb_q   <= mb2_q;
          mp_q   <= '0;
          mcnt_q <= CntBits'(WordBits);
          mpre_q <= 1'b0;
        end else begin
          mp_q   <= sum_red[WordBits-1:0];
          mb_q   <= {mb_q[WordBits-2:0], 1'b0};
          mcnt_q <= mcnt_q - 1'b1;
          if (mcnt_q == CntBits'(1)) begin
            mbusy_q <= 1'b0;
            case (mdst_q)
              2'd0: acc_q <= sum_red[WordBits-1:0];
              2'd1: sq_q  <= sum_red[WordBits-1:0];
              default: res_q <= sum_red[WordBits-1:0];
            endcase
          end
        end
      end
      if (dbusy_q) begin
        dn_q   <= {dn_q[WordBits-2:0], 1'b0};
        dcnt_q <= dcnt_q - 1'b1;
        if (rtry >= {1'b0, r1_q}) begin
          drem_q <= WordBits'(rtry - {1'b0, r1_q});
          dq_q   <= {dq_q[WordBits-2:0], 1'b1};
        end else begin
          drem_q <= rtry[WordBits-1:0];
          dq_q   <= {dq_q[WordBits-2:0], 1'b0};
        end
        if (dcnt_q == CntBits'(1)) dbusy_q <= 1'b0;
      end
      if (cmd_i.start) begin
        case (cmd_i.op)
          elc_pkg::OpLoadS, elc_pkg::OpLoadE, elc_pkg::OpLoadD: begin
            // Load reduces the base through the divider: base mod p.
            acc_q   <= (mod_q == WordBits'(1)) ? '0 : WordBits'(1);
            r1_q    <= mod_q;
            dn_q    <= (cmd_i.op == elc_pkg::OpLoadS) ? gen_q :
                       (cmd_i.op == elc_pkg::OpLoadE) ? pub_q : c1_q;
            exp_q   <= (cmd_i.op == elc_pkg::OpLoadD) ? prv_q : opd_q;
            drem_q  <= '0;
            dq_q    <= '0;
            dcnt_q  <= CntBits'(WordBits);
            dbusy_q <= 1'b1;
          end
          elc_pkg::OpMulAcc, elc_pkg::OpMulSq, elc_pkg::OpEncMul, elc_pkg::OpDecMul: begin
            ma_q    <= mul_pre ? one_red : red_a;
            mb_q    <= mul_pre ? red_a : red_b;
            mb2_q   <= red_b;
            mpre_q  <= mul_pre;
            mp_q    <= '0;
            mcnt_q  <= CntBits'(WordBits);
            mbusy_q <= 1'b1;
            mdst_q  <= (cmd_i.op == elc_pkg::OpMulAcc) ? 2'd0 :
                       (cmd_i.op == elc_pkg::OpMulSq) ? 2'd1 : 2'd2;
          end
          elc_pkg::OpSaveC1: begin
            c1_q <= acc_q;
            res_q <= acc_q;
          end
          elc_pkg::OpSaveK: k_q <= acc_q;
          elc_pkg::OpInvIni: begin
            // r0 = p, r1 = k' (already reduced), t0 = 0, t1 = 1.
            r0_q <= mod_q;
            r1_q <= acc_q;
            t0_q <= '0;
            t1_q <= Sw'(1);
          end
          elc_pkg::OpInvDiv: begin
            dn_q    <= r0_q;
            drem_q  <= '0;
            dq_q    <= '0;
            dcnt_q  <= CntBits'(WordBits);
            dbusy_q <= 1'b1;
          end
          elc_pkg::OpInvEnd: begin
            if (mod_q >= WordBits'(2) && r0_q == WordBits'(1)) begin
              miss_q <= 1'b0;
              kinv_q <= t0_q[Sw-1] ? WordBits'(t0_q + Sw'(mod_q)) : t0_q[WordBits-1:0];
            end else begin
              miss_q <= 1'b1;
              kinv_q <= '0;
            end
          end
          default: ;
        endcase
      end else if (cmd_i.op == elc_pkg::OpInvDiv && !dbusy_q) begin
        // Quotient ready: advance the Euclid recurrence.
        r0_q <= r1_q;
        r1_q <= drem_q;
        t0_q <= t1_q;
        t1_q <= Sw'(t0_q - Sw'($signed({1'b0, dq_q}) * t1_q));
      end else if ((cmd_i.op == elc_pkg::OpLoadS || cmd_i.op == elc_pkg::OpLoadE ||
                    cmd_i.op == elc_pkg::OpLoadD) && !dbusy_q) begin
        sq_q <= (mod_q == '0) ? '0 : drem_q;
        if (mod_q == '0) acc_q <= '0;
      end
      if (ld_i) opd_q <= WordBits'(opd_i);
      if (cmd_i.op == elc_pkg::OpDecMul && !cmd_i.start && !mbusy_q) begin
        res_q <= miss_q ? '0 : WordBits'((res_q + WordBits'(8'd96)) & WordBits'(8'hff));
      end
    end
  end

  assign sts_o.busy    = mbusy_q | dbusy_q;
  assign sts_o.exp_bit = exp_q[bit_idx_i[$clog2(WordBits)-1:0]] & (bit_idx_i < 6'(WordBits));
  assign sts_o.r1_zero = (r1_q == '0);
  assign sts_o.letter  = (ch >= elc_pkg::LetterFirst) && (ch <= elc_pkg::LetterLast);
  assign sts_o.miss    = miss_q;
  assign res_o = elc_pkg::OpdBits'(res_q);
endmodule
`default_nettype wire

[hdl/elc_ctrl.sv]
// Controller state machine sequencing the cipher datapath.
`timescale 1ns / 1ps
`default_nettype none
module elc_ctrl #(
  parameter int unsigned WordBits = elc_pkg::WordBitsDefault
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  input  wire logic [elc_pkg::ReqBits-1:0] req_i,
  output logic                           in_ready_o,
  output logic                           ld_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [5:0]                     bit_idx_o,
  output elc_pkg::dp_cmd_t               cmd_o,
  input  elc_pkg::dp_sts_t               sts_i
);
  typedef enum logic [10:0] {
    StIdle  = 11'b00000000001,
    StDisp  = 11'b00000000010,
    StLoad  = 11'b00000000100,
    StBit   = 11'b00000001000,
    StMulA  = 11'b00000010000,
    StMulS  = 11'b00000100000,
    StSave  = 11'b00001000000,
    StInvD  = 11'b00010000000,
    StInvE  = 11'b00100000000,
    StOne   = 11'b01000000000,
    StOut   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] pass_q, pass_d;  // 0 c1, 1 k, 2 k'
  logic [5:0] bit_q, bit_d;
  logic [elc_pkg::ReqBits-1:0] req_q;
  logic busy_seen_q, busy_seen_d;

  assign in_ready_o  = (state_q == StIdle);
  assign ld_o        = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == StOut);
  assign bit_idx_o   = bit_q;

  always_comb begin
    state_d = state_q;
    pass_d = pass_q;
    bit_d = bit_q;
    busy_seen_d = 1'b0;
    cmd_o.op = elc_pkg::OpNone;
    cmd_o.start = 1'b0;
    case (state_q)
      StIdle: if (in_valid_i) state_d = StDisp;
      StDisp: begin
        case (req_q)
          elc_pkg::ReqSession: begin
            pass_d = 2'd0;
            cmd_o.op = elc_pkg::OpLoadS;
            cmd_o.start = 1'b1;
            state_d = StLoad;
          end
          elc_pkg::ReqEncrypt: begin
            if (sts_i.letter) begin
              cmd_o.op = elc_pkg::OpEncMul;
              cmd_o.start = 1'b1;
              state_d = StOne;
            end else state_d = StIdle;
          end
          elc_pkg::ReqDecrypt: begin
            cmd_o.op = elc_pkg::OpDecMul;
            cmd_o.start = 1'b1;
            state_d = StOne;
          end
          default: state_d = StIdle;
        endcase
      end
      StLoad: begin
        cmd_o.op = (pass_q == 2'd0) ? elc_pkg::OpLoadS :
                   (pass_q == 2'd1) ? elc_pkg::OpLoadE : elc_pkg::OpLoadD;
        if (!sts_i.busy) begin
          bit_d = '0;
          state_d = StBit;
        end
      end
      StBit: begin
        if (bit_q == 6'(WordBits)) state_d = StSave;
        else if (sts_i.exp_bit) begin
          cmd_o.op = elc_pkg::OpMulAcc;
          cmd_o.start = 1'b1;
          state_d = StMulA;
        end else begin
          cmd_o.op = elc_pkg::OpMulSq;
          cmd_o.start = 1'b1;
          state_d = StMulS;
        end
      end
      StMulA: if (!sts_i.busy) begin
        cmd_o.op = elc_pkg::OpMulSq;
        cmd_o.start = 1'b1;
        state_d = StMulS;
      end
      StMulS: if (!sts_i.busy) begin
        bit_d = bit_q + 6'd1;
        state_d = StBit;
      end
      StSave: begin
        cmd_o.start = 1'b1;
        case (pass_q)
          2'd0: begin
            cmd_o.op = elc_pkg::OpSaveC1;
            pass_d = 2'd1;
            state_d = StDisp;
          end
          2'd1: begin
            cmd_o.op = elc_pkg::OpSaveK;
            pass_d = 2'd2;
            state_d = StDisp;
          end
          default: begin
            cmd_o.op = elc_pkg::OpInvIni;
            state_d = StInvD;
          end
        endcase
      end
      StInvD: begin
        if (sts_i.r1_zero) begin
          cmd_o.op = elc_pkg::OpInvEnd;
          cmd_o.start = 1'b1;
          state_d = StOut;
        end else begin
          cmd_o.op = elc_pkg::OpInvDiv;
          cmd_o.start = 1'b1;
          state_d = StInvE;
        end
      end
      StInvE: begin
        cmd_o.op = elc_pkg::OpInvDiv;
        busy_seen_d = 1'b1;
        if (!sts_i.busy && busy_seen_q) state_d = StInvD;
      end
      StOne: begin
        cmd_o.op = (req_q == elc_pkg::ReqDecrypt) ? elc_pkg::OpDecMul : elc_pkg::OpEncMul;
        if (!sts_i.busy) state_d = StOut;
      end
      StOut: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
    // Session passes one and two re-enter dispatch to load their base.
    if (state_q == StDisp && req_q == elc_pkg::ReqSession && pass_q != 2'd0) begin
      cmd_o.op = (pass_q == 2'd1) ? elc_pkg::OpLoadE : elc_pkg::OpLoadD;
      pass_d = pass_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pass_q <= '0;
      bit_q <= '0;
      req_q <= '0;
      busy_seen_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q <= (state_q == StIdle) ? 2'd0 : pass_d;
      bit_q <= bit_d;
      busy_seen_q <= busy_seen_d;
      if (ld_o) req_q <= req_i;
    end
  end
endmodule
`default_nettype wire

[hdl/elgamal_letter_cipher.sv]
// Top level of the ElGamal letter cipher engine.
// A session transaction runs three modular powers, then the Euclid inverse with one
// divider pass a step. In encrypt and decrypt transactions one multiplier pass reduces
// an operand and a second forms the product; one transaction runs at a time.
// Reset: registers take 29, 2, 1, 0; session state clears and the inverse is missing.
`timescale 1ns / 1ps
`default_nettype none
module elgamal_letter_cipher #(
  parameter int unsigned WordBits = elc_pkg::WordBitsDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [elc_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  wire logic [WordBits-1:0]            cfg_data_i,
  elc_if.sink                                 req_if,
  elc_if.source                               res_if
);
  elc_pkg::dp_cmd_t cmd;
  elc_pkg::dp_sts_t sts;
  logic       ld;
  logic [5:0] bit_idx;
  logic [elc_pkg::OpdBits-1:0] res;

  elc_ctrl #(.WordBits(WordBits)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(req_if.valid),
    .req_i(req_if.data[elc_pkg::OpdBits +: elc_pkg::ReqBits]),
    .in_ready_o(req_if.ready),
    .ld_o(ld),
    .out_valid_o(res_if.valid),
    .out_ready_i(res_if.ready),
    .bit_idx_o(bit_idx),
    .cmd_o(cmd),
    .sts_i(sts)
  );

  elc_dp #(.WordBits(WordBits)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .ld_i(ld),
    .opd_i(req_if.data[elc_pkg::OpdBits-1:0]),
    .bit_idx_i(bit_idx),
    .cmd_i(cmd),
    .sts_o(sts),
    .res_o(res)
  );

  assign res_if.data = {res, sts.miss};
endmodule
`default_nettype wire

[sim/elgamal_letter_cipher_test.sv]
// Self-checking testbench for the ElGamal letter cipher with directed and random transactions.
`timescale 1ns / 1ps
module elgamal_letter_cipher_test;
  import elc_pkg::*;

  localparam logic [ReqBits-1:0] ReqUnused = 2'd3;
  localparam int unsigned SettleCycles = 2400;

  typedef struct packed {
    logic [15:0] value;
    logic        missing;
  } cipher_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  elc_if #(.W(ReqBits + OpdBits)) req_if ();
  elc_if #(.W(17)) res_if ();

  elgamal_letter_cipher u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .req_if(req_if),
    .res_if(res_if)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the registers and the session state.
  longint unsigned p_mod, gen, pub_key, priv_key;
  longint unsigned c1_shadow, key_shadow, inv_shadow;
  bit miss_shadow;

  cipher_out_t pending_q[$];
  logic [15:0] c2_seen[$];
  int errors = 0;
  int n_session = 0, n_encrypt = 0, n_decrypt = 0, n_checked = 0;
  bit send_idle = 1'b1;
  bit take_idle = 1'b1;
  bit hold_off = 1'b0;

  function automatic longint unsigned mod_mul(longint unsigned a, longint unsigned b,
                                              longint unsigned m);
    if (m == 0) return 0;
    return ((a % m) * (b % m)) % m;
  endfunction

  function automatic longint unsigned mod_pow(longint unsigned b, longint unsigned x,
                                              longint unsigned m);
    longint unsigned acc, sq;
    if (m == 0) return 0;
    acc = 1 % m;
    sq = b % m;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) acc = mod_mul(acc, sq, m);
      sq = mod_mul(sq, sq, m);
    end
    return acc;
  endfunction

  function automatic bit mod_inverse(longint unsigned a, longint unsigned m,
                                     output longint unsigned iv);
    longint r0, r1, t0, t1, q, tmp;
    iv = 0;
    if (m < 2) return 1'b0;
    r0 = m;
    r1 = a % m;
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      q = r0 / r1;
      tmp = r0 - q * r1; r0 = r1; r1 = tmp;
      tmp = t0 - q * t1; t0 = t1; t1 = tmp;
    end
    if (r0 != 1) return 1'b0;
    if (t0 < 0) t0 += m;
    iv = t0;
    return 1'b1;
  endfunction

  // Updates the shadow state for one accepted request and forms its result, if it has one.
  function automatic bit predict_cipher(logic [ReqBits-1:0] req, logic [15:0] opd,
                                        output cipher_out_t res);
    longint unsigned kd, iv, v;
    logic [7:0] ch;
    res = '0;
    v = 0;
    case (req)
      ReqSession: begin
        c1_shadow = mod_pow(gen, opd, p_mod);
        key_shadow = mod_pow(pub_key, opd, p_mod);
        kd = mod_pow(c1_shadow, priv_key, p_mod);
        if (mod_inverse(kd, p_mod, iv)) begin
          inv_shadow = iv & 16'hffff;
          miss_shadow = 1'b0;
        end else begin
          inv_shadow = 0;
          miss_shadow = 1'b1;
        end
        v = c1_shadow;
      end
      ReqEncrypt: begin
        ch = opd[7:0];
        if (ch < LetterFirst || ch > LetterLast) return 1'b0;
        v = mod_mul(ch - LetterFirst + LetterBase, key_shadow, p_mod);
      end
      ReqDecrypt: begin
        if (miss_shadow) v = 0;
        else v = (mod_mul(opd, inv_shadow, p_mod) + LetterFirst - LetterBase) & 8'hff;
      end
      default: return 1'b0;
    endcase
    res.value = v[15:0];
    res.missing = miss_shadow;
    return 1'b1;
  endfunction

  task automatic send_item(logic [ReqBits-1:0] req, logic [15:0] opd);
    cipher_out_t res;
    while (send_idle && $urandom_range(99) < 17) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data <= {req, opd};
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    case (req)
      ReqSession: n_session++;
      ReqEncrypt: n_encrypt++;
      ReqDecrypt: n_decrypt++;
      default: ;
    endcase
    if (predict_cipher(req, opd, res)) pending_q.push_back(res);
  endtask

  // Waits until every result has arrived and the block has had time to finish.
  task automatic settle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [15:0] m, logic [15:0] g, logic [15:0] e, logic [15:0] d);
    logic [15:0] vals[4];
    vals = '{m, g, e, d};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= CfgIdxBits'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    p_mod = m; gen = g; pub_key = e; priv_key = d;
  endtask

  task automatic test_reset_values();
    send_item(ReqDecrypt, 16'd5);
    send_item(ReqEncrypt, 16'h0061);
    send_item(ReqSession, 16'd0);
    send_item(ReqSession, 16'hffff);
    send_item(ReqEncrypt, 16'h0061);
    send_item(ReqEncrypt, 16'h007a);
    send_item(ReqEncrypt, 16'h0060);
    send_item(ReqEncrypt, 16'h007b);
    send_item(ReqEncrypt, 16'hff61);
    send_item(ReqEncrypt, 16'h0000);
    send_item(ReqDecrypt, 16'd0);
    send_item(ReqDecrypt, 16'hffff);
    send_item(ReqUnused, 16'h1234);
    settle();
  endtask

  task automatic test_small_modulus();
    write_regs(16'd0, 16'd2, 16'd3, 16'd5);
    send_item(ReqSession, 16'd7);
    send_item(ReqEncrypt, 16'h0062);
    send_item(ReqDecrypt, 16'd9);
    settle();
    write_regs(16'd1, 16'd2, 16'd3, 16'd5);
    send_item(ReqSession, 16'd7);
    send_item(ReqDecrypt, 16'd9);
    settle();
  endtask

  task automatic test_register_extremes();
    write_regs(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_item(ReqSession, 16'hffff);
    send_item(ReqEncrypt, 16'hff7a);
    send_item(ReqDecrypt, 16'hffff);
    settle();
    write_regs(16'd27, 16'd3, 16'd0, 16'd0);
    send_item(ReqSession, 16'd4);
    send_item(ReqDecrypt, 16'd1);
    send_item(ReqEncrypt, 16'h0063);
    settle();
  endtask

  task automatic random_item();
    int sel;
    logic [15:0] opd;
    sel = $urandom_range(99);
    opd = 16'($urandom);
    if (sel < 8) begin
      send_item(ReqSession, opd);
    end else if (sel < 52) begin
      if ($urandom_range(9) < 8) opd[7:0] = 8'($urandom_range(LetterLast, LetterFirst));
      send_item(ReqEncrypt, opd);
      if (pending_q.size() != 0) c2_seen.push_back(pending_q[$].value);
      if (c2_seen.size() > 32) void'(c2_seen.pop_front());
    end else if (sel < 95) begin
      if (c2_seen.size() != 0 && $urandom_range(9) < 7)
        opd = c2_seen[$urandom_range(c2_seen.size() - 1)];
      send_item(ReqDecrypt, opd);
    end else begin
      send_item(ReqUnused, opd);
    end
  endtask

  task automatic test_random_traffic(int phases, int per_phase);
    logic [15:0] primes[8];
    logic [15:0] m, g, d, e;
    primes = '{16'd29, 16'd97, 16'd251, 16'd257, 16'd4099, 16'd32749, 16'd65519, 16'd65521};
    for (int ph = 0; ph < phases; ph++) begin
      m = primes[$urandom_range(7)];
      g = 16'($urandom);
      d = 16'($urandom);
      e = 16'(mod_pow(g, d, m));
      if (ph == phases - 1) e = 16'($urandom);
      write_regs(m, g, e, d);
      c2_seen.delete();
      send_idle = (ph != 1);
      take_idle = (ph != 1);
      send_item(ReqSession, 16'($urandom));
      if (ph == 2) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (800) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int i = 0; i < per_phase; i++) random_item();
      settle();
    end
    send_idle = 1'b1;
    take_idle = 1'b1;
  endtask

  // Result checker and receiver back-pressure.
  always @(posedge clk_i) begin
    cipher_out_t got, want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = res_if.data;
      n_checked++;
      if (pending_q.size() == 0) begin
        $error("unexpected result value %0d flag %0d", got.value, got.missing);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (got.value !== want.value) begin
          $error("out_value expected %0d actual %0d", want.value, got.value);
          errors++;
        end
        if (got.missing !== want.missing) begin
          $error("no_inverse expected %0d actual %0d", want.missing, got.missing);
          errors++;
        end
      end
    end
    res_if.ready <= !hold_off && !(take_idle && $urandom_range(99) < 17);
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.data = '0;
    res_if.ready = 1'b0;
    p_mod = 29; gen = 2; pub_key = 1; priv_key = 0;
    c1_shadow = 0; key_shadow = 0; inv_shadow = 0; miss_shadow = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_small_modulus();
    test_register_extremes();
    test_random_traffic(6, 112);
    $display("Covered %0d session, %0d encrypt and %0d decrypt requests;",
             n_session, n_encrypt, n_decrypt);
    $display("%0d results were compared over several key and modulus settings.", n_checked);
    if (errors == 0) begin
      $display("elgamal_letter_cipher verification clean");
    end else begin
      $display("elgamal_letter_cipher verification failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("elgamal_letter_cipher verification failed");
    $finish;
  end
endmodule

[sim.f]
hdl/elc_pkg.sv
hdl/elc_if.sv
hdl/elc_dp.sv
hdl/elc_ctrl.sv
hdl/elgamal_letter_cipher.sv
sim/elgamal_letter_cipher_test.sv
